[hw/rtl/ede_pkg.sv]
// Shared constants, mode codes and beat types for the edit distance engine.
package ede_pkg;

  localparam int MAX_LEN   = 256;
  localparam int ROW_DEPTH = MAX_LEN + 1;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ROW_W     = LEN_W + 1;
  localparam int CHAR_W    = 8;
  localparam int DIST_W    = 9;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_PROCESS = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [CHAR_W-1:0]  char_in;
  } ede_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic               overflowed;
  } ede_out_t;

endpackage

[hw/rtl/edit_distance_engine.sv]
// Levenshtein edit distance engine: string store, cost row and row-walk sequencer.
//
//   channel   | ports                         | handshake
//   ----------+-------------------------------+------------------------------
//   command   | item (mode, char_in)          | taken when start && !busy
//   result    | result (distance, overflowed) | one-cycle result_valid strobe
//
// Clear and append complete without leaving idle. A second-string byte fetches
// entry 0, then walks the row one entry at a time through the single
// compare/min/increment unit, limited by the one read port of the cost row.
// A query passes through S_QUERY, which registers the result and its strobe.
// Reset clears lengths, overflow flag and sequencer; the string and row stores
// are not cleared, so a clear command must come first. Results cannot be stalled.
module edit_distance_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ede_pkg::ede_in_t  item,
  output logic              result_valid,
  output ede_pkg::ede_out_t result
);
  import ede_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOAD0, S_WALK, S_QUERY} state_t;

  state_t             state;
  logic [LEN_W-1:0]   first_length;
  logic [LEN_W-1:0]   second_length;
  logic               overflow_flag;
  logic [LEN_W-1:0]   col;
  logic [CHAR_W-1:0]  ch;
  logic [ROW_W-1:0]   diag;
  logic [ROW_W-1:0]   left;

  logic [CHAR_W-1:0]  first_string [MAX_LEN];
  logic [ROW_W-1:0]   cost_row [ROW_DEPTH];
  logic [CHAR_W-1:0]  str_q;
  logic [ROW_W-1:0]   row_q;

  logic               accept;
  logic               first_full;
  logic               second_full;
  logic [LEN_W-1:0]   row_raddr;
  logic [IDX_W-1:0]   str_raddr;
  logic               row_we;
  logic [LEN_W-1:0]   row_waddr;
  logic [ROW_W-1:0]   row_wdata;
  logic               str_we;
  logic [ROW_W-1:0]   min_ab;
  logic [ROW_W-1:0]   min_all;
  logic [ROW_W-1:0]   cell_val;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign first_full  = (first_length == LEN_W'(MAX_LEN));
  assign second_full = (second_length == LEN_W'(MAX_LEN));

  // Shared cell unit: match carries the diagonal, else 1 + min of three.
  assign min_ab   = (row_q < left) ? row_q : left;
  assign min_all  = (diag < min_ab) ? diag : min_ab;
  assign cell_val = (str_q == ch) ? diag : ROW_W'(min_all + 1'b1);

  always_comb begin
    row_we    = 1'b0;
    row_waddr = '0;
    row_wdata = '0;
    str_we    = 1'b0;
    row_raddr = LEN_W'(col + 1'b1);
    unique case (state)
      S_IDLE: begin
        row_raddr = (item.mode == MODE_QUERY) ? first_length : '0;
        if (accept) begin
          unique case (item.mode)
            MODE_CLEAR: begin
              row_we = 1'b1;
            end
            MODE_APPEND: begin
              if (!first_full) begin
                row_we    = 1'b1;
                str_we    = 1'b1;
                row_waddr = LEN_W'(first_length + 1'b1);
                row_wdata = ROW_W'(first_length + 1'b1);
              end
            end
            MODE_PROCESS: ;
            MODE_QUERY: ;
          endcase
        end
      end
      S_LOAD0: begin
        row_raddr = LEN_W'(1);
        row_we    = 1'b1;
        row_wdata = ROW_W'(second_length + 1'b1);
      end
      S_WALK: begin
        row_we    = 1'b1;
        row_waddr = col;
        row_wdata = cell_val;
      end
      S_QUERY: ;
    endcase
  end

  // String entry i-1 pairs with row entry i.
  assign str_raddr = IDX_W'(row_raddr - 1'b1);

  always_ff @(posedge clk) begin
    if (row_we) begin
      cost_row[row_waddr] <= row_wdata;
    end
    if (str_we) begin
      first_string[first_length[IDX_W-1:0]] <= item.char_in;
    end
    row_q <= cost_row[row_raddr];
    str_q <= first_string[str_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_length  <= '0;
      second_length <= '0;
      overflow_flag <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.mode)
              MODE_CLEAR: begin
                first_length  <= '0;
                second_length <= '0;
                overflow_flag <= 1'b0;
              end
              MODE_APPEND: begin
                if (first_full) begin
                  overflow_flag <= 1'b1;
                end else begin
                  first_length <= LEN_W'(first_length + 1'b1);
                end
              end
              MODE_PROCESS: begin
                if (second_full) begin
                  overflow_flag <= 1'b1;
                end else begin
                  ch    <= item.char_in;
                  state <= S_LOAD0;
                end
              end
              MODE_QUERY: begin
                state <= S_QUERY;
              end
            endcase
          end
        end
        S_LOAD0: begin
          diag          <= row_q;
          left          <= row_wdata;
          second_length <= LEN_W'(second_length + 1'b1);
          col           <= LEN_W'(1);
          state         <= (first_length == '0) ? S_IDLE : S_WALK;
        end
        S_WALK: begin
          // advance one entry; old value becomes the next diagonal
          diag <= row_q;
          left <= cell_val;
          col  <= LEN_W'(col + 1'b1);
          if (col == first_length) begin
            state <= S_IDLE;
          end
        end
        S_QUERY: begin
          result.distance   <= DIST_W'(row_q);
          result.overflowed <= overflow_flag;
          result_valid      <= 1'b1;
          state             <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_after_query: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_QUERY))
    else $error("result strobe without a query");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (col != '0 && col <= first_length))
    else $error("row walk index out of range");

  a_lengths_bounded: assert property (@(posedge clk) disable iff (rst)
    (first_length <= LEN_W'(MAX_LEN)) && (second_length <= LEN_W'(MAX_LEN)))
    else $error("string length beyond limit");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && item.mode == MODE_QUERY) |=> busy ##1 result_valid)
    else $error("query did not produce a result");
`endif

endmodule
